/* sv/lkvc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_pkg: shared definitions for the LRU key-value cache
// Widths, reset values, opcodes and the controller-to-datapath command bundle.
// ----------------------------------------------------------------------------
package lkvc_pkg;

    // Default table depth
    localparam int ENTRIES_DEFAULT = 16;

    // Fixed field widths
    localparam int CAP_W  = 5;
    localparam int DATA_W = 32;

    // Capacity after reset
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Opcodes
    localparam logic OP_GET = 1'b0;
    localparam logic OP_SET = 1'b1;

    // Value returned by a get that misses
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

    // Commands from controller to datapath, one per phase of an item
    typedef struct packed {
        logic load;    // capture the accepted item
        logic search;  // register key compare, free slot and victim
        logic commit;  // update table and ranks, read stored value
        logic push;    // load the output register
    } ctrl_cmd_t;

endpackage
`default_nettype wire

/* sv/lkvc_req_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_req_if: request channel of the LRU key-value cache
// Valid/ready handshake carrying opcode, key and write value.
// ----------------------------------------------------------------------------
interface lkvc_req_if;

    logic                              valid;
    logic                              ready;
    logic                              opcode;
    logic signed [lkvc_pkg::DATA_W-1:0] key;
    logic signed [lkvc_pkg::DATA_W-1:0] write_value;

    modport source (output valid, output opcode, output key, output write_value,
                    input ready);
    modport sink   (input valid, input opcode, input key, input write_value,
                    output ready);

endinterface
`default_nettype wire

/* sv/lkvc_rsp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_rsp_if: response channel of the LRU key-value cache
// Valid/ready handshake carrying the hit flag and the read value.
// ----------------------------------------------------------------------------
interface lkvc_rsp_if;

    logic                              valid;
    logic                              ready;
    logic                              hit;
    logic signed [lkvc_pkg::DATA_W-1:0] read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);

endinterface
`default_nettype wire

/* sv/lkvc_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_ctrl: sequencer of the LRU key-value cache
// Steps each item through search, commit and push, and owns both handshakes.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic                out_ready,
    output logic                     out_valid,
    output lkvc_pkg::ctrl_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMMIT,
        ST_PUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // Output register can take a new item when empty or being drained
    assign out_free = !out_valid_reg || out_ready;

    // Commands and next state
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                cmd.search = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    cmd.push       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered handshake outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

/* sv/lkvc_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_datapath: entry table, key compare and recency ranks
// Parallel key compare over the entry cells, rank shifter, data memory and
// the output register.
// ----------------------------------------------------------------------------
module lkvc_datapath #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [lkvc_pkg::CAP_W-1:0]          cfg_wdata,
    input  wire lkvc_pkg::ctrl_cmd_t                 cmd,
    input  wire logic                                in_opcode,
    input  wire logic signed [lkvc_pkg::DATA_W-1:0]  in_key,
    input  wire logic signed [lkvc_pkg::DATA_W-1:0]  in_write_value,
    output logic                                     out_hit,
    output logic signed [lkvc_pkg::DATA_W-1:0]       out_read_value
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int OCC_W  = $clog2(ENTRIES + 1);
    localparam int DW     = lkvc_pkg::DATA_W;

    // Configuration
    logic [lkvc_pkg::CAP_W-1:0] cap_reg;
    logic [OCC_W-1:0]           cap_eff;

    // Captured item
    logic                       op_reg;
    logic [DW-1:0]              key_in_reg;
    logic [DW-1:0]              wval_reg;
    logic [OCC_W-1:0]           cap_eff_reg;

    // Table
    logic [ENTRIES-1:0]         valid_reg;
    logic [RANK_W-1:0]          rank_reg [ENTRIES];
    logic [DW-1:0]              entry_key_reg [ENTRIES];
    logic [DW-1:0]              entry_data_reg [ENTRIES];
    logic [OCC_W-1:0]           occ_reg;

    // Search results
    logic                       hit_reg;
    logic                       upd_reg;
    logic                       wr_data_reg;
    logic                       new_key_reg;
    logic                       insert_reg;
    logic [IDX_W-1:0]           tgt_idx_reg;
    logic [OCC_W-1:0]           old_rank_reg;

    // Read and output
    logic [DW-1:0]              rd_data_reg;
    logic                       out_hit_reg;
    logic [DW-1:0]              out_value_reg;

    // Search logic
    logic                       hit_any;
    logic [IDX_W-1:0]           hit_idx;
    logic [RANK_W-1:0]          hit_rank;
    logic [IDX_W-1:0]           free_idx;
    logic [IDX_W-1:0]           victim_idx;
    logic [OCC_W-1:0]           occ_last;
    logic                       cap_zero;
    logic                       room;
    logic                       is_set;

    // Capacity above the table depth counts as the full table
    always_comb
    begin
        if (int'(cap_reg) > ENTRIES)
            cap_eff = OCC_W'(ENTRIES);
        else
            cap_eff = OCC_W'(cap_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= lkvc_pkg::CAP_RESET;
        else if (cfg_we)
            cap_reg <= cfg_wdata;
    end

    // Item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= in_opcode;
            key_in_reg  <= in_key;
            wval_reg    <= in_write_value;
            cap_eff_reg <= cap_eff;
        end
    end

    // Key compare, lowest free slot and least recent entry (lowest index wins)
    assign occ_last = occ_reg - OCC_W'(1);

    always_comb
    begin
        hit_any    = 1'b0;
        hit_idx    = '0;
        hit_rank   = '0;
        free_idx   = '0;
        victim_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && (entry_key_reg[i] == key_in_reg))
            begin
                hit_any  = 1'b1;
                hit_idx  = IDX_W'(i);
                hit_rank = rank_reg[i];
            end
            if (!valid_reg[i])
                free_idx = IDX_W'(i);
            if (valid_reg[i] && (OCC_W'(rank_reg[i]) == occ_last))
                victim_idx = IDX_W'(i);
        end
    end

    assign cap_zero = (cap_eff_reg == '0);
    assign room     = (occ_reg < cap_eff_reg);
    assign is_set   = (op_reg == lkvc_pkg::OP_SET);

    // Decide what the commit phase does
    always_ff @(posedge clk)
    begin
        if (cmd.search)
        begin
            hit_reg     <= !cap_zero && hit_any;
            upd_reg     <= !cap_zero && (hit_any || is_set);
            wr_data_reg <= !cap_zero && is_set;
            new_key_reg <= !cap_zero && is_set && !hit_any;
            insert_reg  <= !cap_zero && is_set && !hit_any && room;
            if (hit_any)
            begin
                tgt_idx_reg  <= hit_idx;
                old_rank_reg <= OCC_W'(hit_rank);
            end
            else if (room)
            begin
                tgt_idx_reg  <= free_idx;
                old_rank_reg <= occ_reg;
            end
            else
            begin
                tgt_idx_reg  <= victim_idx;
                old_rank_reg <= occ_last;
            end
        end
    end

    // Data memory and key cells: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            rd_data_reg <= entry_data_reg[tgt_idx_reg];
            if (wr_data_reg)
                entry_data_reg[tgt_idx_reg] <= wval_reg;
            if (new_key_reg)
                entry_key_reg[tgt_idx_reg] <= key_in_reg;
        end
    end

    // Valid bits, recency ranks and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            occ_reg   <= '0;
            for (int i = 0; i < ENTRIES; i++)
                rank_reg[i] <= '0;
        end
        else if (cmd.commit && upd_reg)
        begin
            // Target becomes most recent; more recent entries age by one
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (tgt_idx_reg == IDX_W'(i))
                    rank_reg[i] <= '0;
                else if (valid_reg[i] && (OCC_W'(rank_reg[i]) < old_rank_reg))
                    rank_reg[i] <= rank_reg[i] + RANK_W'(1);
            end
            if (insert_reg)
            begin
                valid_reg[tgt_idx_reg] <= 1'b1;
                occ_reg                <= occ_reg + OCC_W'(1);
            end
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_hit_reg <= hit_reg;
            if (is_set)
                out_value_reg <= '0;
            else if (hit_reg)
                out_value_reg <= rd_data_reg;
            else
                out_value_reg <= lkvc_pkg::MISS_VALUE;
        end
    end

    assign out_hit        = out_hit_reg;
    assign out_read_value = out_value_reg;

endmodule
`default_nettype wire

/* sv/lru_key_value_cache.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value cache, LRU replacement
// Each item passes capture, search, commit and push in turn; the push waits while
//   the output register holds an unaccepted result. Only one item is in progress,
//   held by the single-item sequencer around the key compare and rank update.
// A new request is taken while the previous result still waits in the output
//   register. Reset (rst_n, async) empties the table and sets capacity to 16.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    lkvc_req_if.sink                         req,
    lkvc_rsp_if.source                       rsp,
    input  wire logic                        cfg_we,
    input  wire logic [lkvc_pkg::CAP_W-1:0]  cfg_wdata
);

    lkvc_pkg::ctrl_cmd_t cmd;

    // Sequencer
    lkvc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .cmd       (cmd)
    );

    // Table and result path
    lkvc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .cmd            (cmd),
        .in_opcode      (req.opcode),
        .in_key         (req.key),
        .in_write_value (req.write_value),
        .out_hit        (rsp.hit),
        .out_read_value (rsp.read_value)
    );

endmodule
`default_nettype wire

/* sv/lkvc_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_checker: port-level checks for the LRU key-value cache
// Watches both handshakes and the result encoding; bound to the top level.
// ----------------------------------------------------------------------------
module lkvc_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    input  wire logic                                in_ready,
    input  wire logic                                out_valid,
    input  wire logic                                out_ready,
    input  wire logic                                out_hit,
    input  wire logic signed [lkvc_pkg::DATA_W-1:0]  out_read_value
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_hit) && $stable(out_read_value))
        else $error("result payload changed while stalled");

    // One item at a time: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while an item is in progress");

    // Without a hit, a get gives the miss marker and a set gives zero
    a_miss_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_hit |->
            (out_read_value == lkvc_pkg::MISS_VALUE) || (out_read_value == '0))
        else $error("miss result carries a stored value");

endmodule

bind lru_key_value_cache lkvc_checker u_lkvc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (req.valid),
    .in_ready       (req.ready),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .out_hit        (rsp.hit),
    .out_read_value (rsp.read_value)
);
`default_nettype wire
